// File: rtl/core/rvdec_pkg.sv
// ----------------------------------------------------------------------------
// RV64I decoder package
// Opcodes, function codes, instruction ids and the decode result type.
// ----------------------------------------------------------------------------
`default_nettype none

package rvdec_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned IdWidth   = 6;
  localparam int unsigned RegWidth  = 5;

  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_AUIPC    = 7'h17;
  localparam logic [6:0] OPC_OP_IMM32 = 7'h1b;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_OP32     = 7'h3b;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_JAL      = 7'h6f;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] F3_0 = 3'd0;
  localparam logic [2:0] F3_1 = 3'd1;
  localparam logic [2:0] F3_2 = 3'd2;
  localparam logic [2:0] F3_3 = 3'd3;
  localparam logic [2:0] F3_4 = 3'd4;
  localparam logic [2:0] F3_5 = 3'd5;
  localparam logic [2:0] F3_6 = 3'd6;
  localparam logic [2:0] F3_7 = 3'd7;

  typedef enum logic [IdWidth-1:0] {
    ID_ADD, ID_SUB, ID_SLL, ID_SLT, ID_SLTU, ID_XOR, ID_SRL, ID_SRA, ID_OR, ID_AND,
    ID_ADDW, ID_SLLW, ID_SRLW, ID_SUBW, ID_SRAW,
    ID_JALR, ID_LB, ID_LH, ID_LW, ID_LBU, ID_LHU, ID_ADDI, ID_SLTI, ID_SLTIU,
    ID_XORI, ID_ORI, ID_ANDI, ID_LWU, ID_LD, ID_SLLI, ID_SRLI, ID_SRAI,
    ID_ADDIW, ID_SLLIW, ID_SRLIW, ID_SRAIW,
    ID_SB, ID_SH, ID_SW, ID_SD,
    ID_BEQ, ID_BNE, ID_BLT, ID_BGE, ID_BLTU, ID_BGEU,
    ID_LUI, ID_AUIPC, ID_JAL
  } instr_id_e;

  typedef enum logic [2:0] {
    FMT_R, FMT_I, FMT_S, FMT_B, FMT_U, FMT_J
  } fmt_e;

  typedef struct packed {
    logic                 illegal;
    logic [IdWidth-1:0]   instr_id;
    logic [RegWidth-1:0]  dest_reg;
    logic [RegWidth-1:0]  src_reg_one;
    logic [RegWidth-1:0]  src_reg_two;
    logic [WordWidth-1:0] immediate;
  } dec_result_t;

endpackage

`default_nettype wire

// File: rtl/core/rvdec_decode.sv
// ----------------------------------------------------------------------------
// RV64I decode logic
// Matches one instruction word and extracts its id, registers and immediate.
// ----------------------------------------------------------------------------
`default_nettype none

module rvdec_decode (
  input  logic [rvdec_pkg::WordWidth-1:0] word_i,
  output rvdec_pkg::dec_result_t          result_o
);
  import rvdec_pkg::*;

  logic [6:0] opcode;
  logic [2:0] funct3;
  logic [6:0] funct7;
  logic       alt;
  logic       legal;
  instr_id_e  id;
  fmt_e       fmt;

  assign opcode = word_i[6:0];
  assign funct3 = word_i[14:12];
  assign funct7 = word_i[31:25];
  assign alt    = word_i[30];

  always_comb begin
    legal = 1'b1;
    id    = ID_ADD;
    fmt   = FMT_R;
    case (opcode)
      OPC_OP: begin
        fmt = FMT_R;
        if (funct7 == F7_BASE) begin
          case (funct3)
            F3_0: id = ID_ADD;
            F3_1: id = ID_SLL;
            F3_2: id = ID_SLT;
            F3_3: id = ID_SLTU;
            F3_4: id = ID_XOR;
            F3_5: id = ID_SRL;
            F3_6: id = ID_OR;
            default: id = ID_AND;
          endcase
        end else if (funct7 == F7_ALT && funct3 == F3_0) begin
          id = ID_SUB;
        end else if (funct7 == F7_ALT && funct3 == F3_5) begin
          id = ID_SRA;
        end else begin
          legal = 1'b0;
        end
      end
      OPC_OP32: begin
        fmt = FMT_R;
        if (funct7 == F7_BASE && funct3 == F3_0) begin
          id = ID_ADDW;
        end else if (funct7 == F7_BASE && funct3 == F3_1) begin
          id = ID_SLLW;
        end else if (funct7 == F7_BASE && funct3 == F3_5) begin
          id = ID_SRLW;
        end else if (funct7 == F7_ALT && funct3 == F3_0) begin
          id = ID_SUBW;
        end else if (funct7 == F7_ALT && funct3 == F3_5) begin
          id = ID_SRAW;
        end else begin
          legal = 1'b0;
        end
      end
      OPC_JALR: begin
        fmt   = FMT_I;
        id    = ID_JALR;
        legal = (funct3 == F3_0);
      end
      OPC_LOAD: begin
        fmt = FMT_I;
        case (funct3)
          F3_0: id = ID_LB;
          F3_1: id = ID_LH;
          F3_2: id = ID_LW;
          F3_3: id = ID_LD;
          F3_4: id = ID_LBU;
          F3_5: id = ID_LHU;
          F3_6: id = ID_LWU;
          default: legal = 1'b0;
        endcase
      end
      OPC_OP_IMM: begin
        fmt = FMT_I;
        case (funct3)
          F3_0: id = ID_ADDI;
          F3_1: id = ID_SLLI;
          F3_2: id = ID_SLTI;
          F3_3: id = ID_SLTIU;
          F3_4: id = ID_XORI;
          F3_5: id = alt ? ID_SRAI : ID_SRLI;
          F3_6: id = ID_ORI;
          default: id = ID_ANDI;
        endcase
      end
      OPC_OP_IMM32: begin
        fmt = FMT_I;
        case (funct3)
          F3_0: id = ID_ADDIW;
          F3_1: id = ID_SLLIW;
          F3_5: id = alt ? ID_SRAIW : ID_SRLIW;
          default: legal = 1'b0;
        endcase
      end
      OPC_STORE: begin
        fmt = FMT_S;
        case (funct3)
          F3_0: id = ID_SB;
          F3_1: id = ID_SH;
          F3_2: id = ID_SW;
          F3_3: id = ID_SD;
          default: legal = 1'b0;
        endcase
      end
      OPC_BRANCH: begin
        fmt = FMT_B;
        case (funct3)
          F3_0: id = ID_BEQ;
          F3_1: id = ID_BNE;
          F3_4: id = ID_BLT;
          F3_5: id = ID_BGE;
          F3_6: id = ID_BLTU;
          F3_7: id = ID_BGEU;
          default: legal = 1'b0;
        endcase
      end
      OPC_LUI: begin
        fmt = FMT_U;
        id  = ID_LUI;
      end
      OPC_AUIPC: begin
        fmt = FMT_U;
        id  = ID_AUIPC;
      end
      OPC_JAL: begin
        fmt = FMT_J;
        id  = ID_JAL;
      end
      default: legal = 1'b0;
    endcase
  end

  always_comb begin
    result_o = '0;
    if (!legal) begin
      result_o.illegal = 1'b1;
    end else begin
      result_o.instr_id = id;
      case (fmt)
        FMT_R: begin
          result_o.dest_reg    = word_i[11:7];
          result_o.src_reg_one = word_i[19:15];
          result_o.src_reg_two = word_i[24:20];
        end
        FMT_I: begin
          result_o.dest_reg    = word_i[11:7];
          result_o.src_reg_one = word_i[19:15];
          result_o.immediate   = {{20{word_i[31]}}, word_i[31:20]};
        end
        FMT_S: begin
          result_o.src_reg_one = word_i[19:15];
          result_o.src_reg_two = word_i[24:20];
          result_o.immediate   = {{20{word_i[31]}}, word_i[31:25], word_i[11:7]};
        end
        FMT_B: begin
          result_o.src_reg_one = word_i[19:15];
          result_o.src_reg_two = word_i[24:20];
          result_o.immediate   = {{19{word_i[31]}}, word_i[31], word_i[7],
                                  word_i[30:25], word_i[11:8], 1'b0};
        end
        FMT_U: begin
          result_o.dest_reg  = word_i[11:7];
          result_o.immediate = {word_i[31:12], 12'b0};
        end
        default: begin
          result_o.dest_reg  = word_i[11:7];
          result_o.immediate = {{11{word_i[31]}}, word_i[31], word_i[19:12],
                                word_i[20], word_i[30:21], 1'b0};
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rv64i_instruction_decoder_unit.sv
// ----------------------------------------------------------------------------
// RV64I instruction decoder unit
// Registers one instruction word, decodes it and registers the result.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// command   in         start_i, busy_o     instruction_word_i
// result    out        done_o              illegal_o, instr_id_o, dest_reg_o,
//                                          src_reg_one_o, src_reg_two_o,
//                                          immediate_o
//
// A word is taken at every clock edge with start_i high; busy_o is always low.
// Its result shows on the result ports with done_o once it has passed through the
// input register and then the result register that lie around the decode.
// A new word may follow every cycle, and results leave in the order taken.
// Reset clears both valid flags; no result is produced until a word arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64i_instruction_decoder_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [rvdec_pkg::WordWidth-1:0]       instruction_word_i,
  output logic                                  done_o,
  output logic                                  illegal_o,
  output logic [rvdec_pkg::IdWidth-1:0]         instr_id_o,
  output logic [rvdec_pkg::RegWidth-1:0]        dest_reg_o,
  output logic [rvdec_pkg::RegWidth-1:0]        src_reg_one_o,
  output logic [rvdec_pkg::RegWidth-1:0]        src_reg_two_o,
  output logic signed [rvdec_pkg::WordWidth-1:0] immediate_o
);
  import rvdec_pkg::*;

  logic                 word_vld_q;
  logic [WordWidth-1:0] word_q;
  logic                 res_vld_q;
  dec_result_t          res_d;
  dec_result_t          res_q;
  logic                 accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      word_vld_q <= accept;
      res_vld_q  <= word_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= instruction_word_i;
    end
    if (word_vld_q) begin
      res_q <= res_d;
    end
  end

  rvdec_decode u_decode (
    .word_i   (word_q),
    .result_o (res_d)
  );

  assign done_o        = res_vld_q;
  assign illegal_o     = res_q.illegal;
  assign instr_id_o    = res_q.instr_id;
  assign dest_reg_o    = res_q.dest_reg;
  assign src_reg_one_o = res_q.src_reg_one;
  assign src_reg_two_o = res_q.src_reg_two;
  assign immediate_o   = $signed(res_q.immediate);

endmodule

`default_nettype wire
